// ----- src/spmq_pkg.sv -----
package spmq_pkg;

  typedef enum logic [2:0] {
    MODE_PUSH   = 3'd0,
    MODE_POP    = 3'd1,
    MODE_PEEKF  = 3'd2,
    MODE_PEEKB  = 3'd3,
    MODE_STATS  = 3'd4
  } mode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_EMPTY   = 2'd1,
    ST_FULL    = 2'd2,
    ST_BADPRIO = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_LOOK,
    S_DATA
  } state_t;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  prio;
    logic [15:0] pages;
    logic [15:0] tag;
    logic [31:0] now;
  } cmd_t;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] pages;
    logic [31:0] enter;
  } slot_t;

  function automatic logic [31:0] sat_add(input logic [31:0] a, input logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? 32'hFFFF_FFFF : s[31:0];
  endfunction

endpackage

// ----- src/strict_priority_multi_queue.sv -----
// channel   | handshake                 | payload
// ----------+---------------------------+--------------------------------------------
// command   | start / busy              | mode, priority_level, job_pages, job_tag, now
// result    | done (one-cycle strobe)   | status, item_*, queue_count, level_*
// config    | cfg_valid / cfg_ready     | cfg_data (levels_in_use)
//
// A push, a stats read or a miss finishes in the back end's LOOK state; a pop or peek
// that finds a job goes on to the DATA state for the registered job memory read.
// A two-entry command queue sits in front; busy rises only when it is full.
// rst is synchronous; it empties all levels, clears totals and sets levels_in_use to 8.
// Results are never held off: done marks each one for a single cycle.
module strict_priority_multi_queue #(
  parameter int MAX_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [2:0]  mode,
  input  logic [3:0]  priority_level,
  input  logic [15:0] job_pages,
  input  logic [15:0] job_tag,
  input  logic [31:0] now,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data,
  output logic        done,
  output logic [1:0]  status,
  output logic [15:0] item_tag,
  output logic [3:0]  item_priority,
  output logic [15:0] item_pages,
  output logic [31:0] item_enter_time,
  output logic [31:0] item_wait,
  output logic [7:0]  queue_count,
  output logic [31:0] level_jobs,
  output logic [31:0] level_pages,
  output logic [31:0] level_wait
);

  logic [3:0]     levels_in_use;
  spmq_pkg::cmd_t cmd_in;
  spmq_pkg::cmd_t cmd;
  logic           cmd_valid;
  logic           cmd_take;

  assign cfg_ready = 1'b1;
  assign cmd_in = '{mode: mode, prio: priority_level, pages: job_pages, tag: job_tag, now: now};

  always_ff @(posedge clk) begin
    if (rst) begin
      levels_in_use <= 4'd8;
    end else if (cfg_valid && cfg_ready) begin
      levels_in_use <= cfg_data;
    end
  end

  spmq_front u_front (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .cmd_in    (cmd_in),
    .busy      (busy),
    .cmd_valid (cmd_valid),
    .cmd       (cmd),
    .cmd_take  (cmd_take)
  );

  spmq_back #(
    .MAX_LEVELS  (MAX_LEVELS),
    .LEVEL_DEPTH (LEVEL_DEPTH)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .levels_in_use   (levels_in_use),
    .cmd_valid       (cmd_valid),
    .cmd             (cmd),
    .cmd_take        (cmd_take),
    .done            (done),
    .status          (status),
    .item_tag        (item_tag),
    .item_priority   (item_priority),
    .item_pages      (item_pages),
    .item_enter_time (item_enter_time),
    .item_wait       (item_wait),
    .queue_count     (queue_count),
    .level_jobs      (level_jobs),
    .level_pages     (level_pages),
    .level_wait      (level_wait)
  );

endmodule

// ----- src/spmq_front.sv -----
module spmq_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  spmq_pkg::cmd_t    cmd_in,
  output logic              busy,
  output logic              cmd_valid,
  output spmq_pkg::cmd_t    cmd,
  input  logic              cmd_take
);

  spmq_pkg::cmd_t q [2];
  logic           wr_ptr;
  logic           rd_ptr;
  logic [1:0]     cnt;
  logic           push;

  assign busy      = (cnt == 2'd2);
  assign push      = start && !busy;
  assign cmd_valid = (cnt != 2'd0);
  assign cmd       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wr_ptr] <= cmd_in;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      cnt    <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (cmd_take) begin
        rd_ptr <= !rd_ptr;
      end
      cnt <= cnt + 2'(push) - 2'(cmd_take);
    end
  end

endmodule

// ----- src/spmq_back.sv -----
module spmq_back #(
  parameter int MAX_LEVELS  = 8,
  parameter int LEVEL_DEPTH = 16
) (
  input  logic             clk,
  input  logic             rst,
  input  logic [3:0]       levels_in_use,
  input  logic             cmd_valid,
  input  spmq_pkg::cmd_t   cmd,
  output logic             cmd_take,
  output logic             done,
  output logic [1:0]       status,
  output logic [15:0]      item_tag,
  output logic [3:0]       item_priority,
  output logic [15:0]      item_pages,
  output logic [31:0]      item_enter_time,
  output logic [31:0]      item_wait,
  output logic [7:0]       queue_count,
  output logic [31:0]      level_jobs,
  output logic [31:0]      level_pages,
  output logic [31:0]      level_wait
);

  localparam int LW    = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
  localparam int IW    = $clog2(LEVEL_DEPTH);
  localparam int FW    = $clog2(LEVEL_DEPTH + 1);
  localparam int ENT   = MAX_LEVELS * LEVEL_DEPTH;
  localparam int AW    = $clog2(ENT);
  localparam int TW    = $clog2(ENT + 1);
  localparam logic [IW-1:0] LAST_POS = IW'(LEVEL_DEPTH - 1);
  localparam logic [FW-1:0] FULL_FILL = FW'(LEVEL_DEPTH);

  spmq_pkg::state_t state, state_next;
  spmq_pkg::cmd_t   c;
  spmq_pkg::slot_t  mem [ENT];
  spmq_pkg::slot_t  rd_data;

  logic [IW-1:0] head  [MAX_LEVELS];
  logic [IW-1:0] tail  [MAX_LEVELS];
  logic [FW-1:0] fill  [MAX_LEVELS];
  logic [31:0]   jobs  [MAX_LEVELS];
  logic [31:0]   pages [MAX_LEVELS];
  logic [31:0]   waits [MAX_LEVELS];
  logic [TW-1:0] total;
  logic [LW-1:0] lvl;

  logic [4:0]    eff;
  logic          prio_ok;
  logic [LW-1:0] plvl;
  logic          found;
  logic [LW-1:0] sel_front, sel_back, sel;
  logic [IW-1:0] pos;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [IW-1:0] ptr_inc;
  logic [31:0]   wait_val;
  logic [31:0]   total_w;

  always_comb begin
    eff = ({1'b0, levels_in_use} > 5'(MAX_LEVELS)) ? 5'(MAX_LEVELS) : {1'b0, levels_in_use};
    prio_ok = (c.prio != 4'd0) && ({1'b0, c.prio} <= eff);
    plvl = LW'(c.prio - 4'd1);
    sel_front = '0;
    sel_back  = '0;
    found     = 1'b0;
    for (int i = MAX_LEVELS - 1; i >= 0; i--) begin
      if (fill[i] != '0 && 5'(i) < eff) begin
        sel_front = LW'(i);
        found     = 1'b1;
      end
    end
    for (int i = 0; i < MAX_LEVELS; i++) begin
      if (fill[i] != '0 && 5'(i) < eff) begin
        sel_back = LW'(i);
      end
    end
    sel = (c.mode == spmq_pkg::MODE_PEEKB) ? sel_back : sel_front;
    if (c.mode == spmq_pkg::MODE_PEEKB) begin
      pos = (tail[sel] == '0) ? LAST_POS : tail[sel] - IW'(1);
    end else begin
      pos = head[sel];
    end
    rd_addr  = AW'(sel) * AW'(LEVEL_DEPTH) + AW'(pos);
    wr_addr  = AW'(plvl) * AW'(LEVEL_DEPTH) + AW'(tail[plvl]);
    ptr_inc  = '0;
    wait_val = c.now - rd_data.enter;
    total_w  = 32'(total);
  end

  always_comb begin
    state_next = state;
    cmd_take   = 1'b0;
    case (state)
      spmq_pkg::S_IDLE: begin
        if (cmd_valid) begin
          cmd_take   = 1'b1;
          state_next = spmq_pkg::S_LOOK;
        end
      end
      spmq_pkg::S_LOOK: begin
        if ((c.mode == spmq_pkg::MODE_POP || c.mode == spmq_pkg::MODE_PEEKF ||
             c.mode == spmq_pkg::MODE_PEEKB) && found) begin
          state_next = spmq_pkg::S_DATA;
        end else begin
          state_next = spmq_pkg::S_IDLE;
        end
      end
      spmq_pkg::S_DATA: state_next = spmq_pkg::S_IDLE;
      default: state_next = spmq_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= spmq_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (state == spmq_pkg::S_LOOK) begin
      rd_data <= mem[rd_addr];
      if (c.mode == spmq_pkg::MODE_PUSH && prio_ok && fill[plvl] != FULL_FILL) begin
        mem[wr_addr] <= '{tag: c.tag, pages: c.pages, enter: c.now};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_take) begin
      c <= cmd;
    end
    if (state == spmq_pkg::S_LOOK) begin
      lvl <= sel;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MAX_LEVELS; i++) begin
        head[i]  <= '0;
        tail[i]  <= '0;
        fill[i]  <= '0;
        jobs[i]  <= '0;
        pages[i] <= '0;
        waits[i] <= '0;
      end
      total           <= '0;
      done            <= 1'b0;
      status          <= spmq_pkg::ST_OK;
      item_tag        <= '0;
      item_priority   <= '0;
      item_pages      <= '0;
      item_enter_time <= '0;
      item_wait       <= '0;
      queue_count     <= '0;
      level_jobs      <= '0;
      level_pages     <= '0;
      level_wait      <= '0;
    end else begin
      done <= 1'b0;
      if (state == spmq_pkg::S_LOOK && state_next == spmq_pkg::S_IDLE) begin
        done            <= 1'b1;
        status          <= spmq_pkg::ST_OK;
        item_tag        <= '0;
        item_priority   <= '0;
        item_pages      <= '0;
        item_enter_time <= '0;
        item_wait       <= '0;
        level_jobs      <= '0;
        level_pages     <= '0;
        level_wait      <= '0;
        queue_count     <= total_w[7:0];
        case (c.mode)
          spmq_pkg::MODE_PUSH: begin
            if (!prio_ok) begin
              status <= spmq_pkg::ST_BADPRIO;
            end else if (fill[plvl] == FULL_FILL) begin
              status <= spmq_pkg::ST_FULL;
            end else begin
              tail[plvl]  <= (tail[plvl] == LAST_POS) ? '0 : tail[plvl] + IW'(1);
              fill[plvl]  <= fill[plvl] + FW'(1);
              jobs[plvl]  <= spmq_pkg::sat_add(jobs[plvl], 32'd1);
              pages[plvl] <= spmq_pkg::sat_add(pages[plvl], 32'(c.pages));
              total       <= total + TW'(1);
              queue_count <= 8'(total_w + 32'd1);
            end
          end
          spmq_pkg::MODE_POP, spmq_pkg::MODE_PEEKF, spmq_pkg::MODE_PEEKB: begin
            status <= spmq_pkg::ST_EMPTY;
          end
          spmq_pkg::MODE_STATS: begin
            if (!prio_ok) begin
              status <= spmq_pkg::ST_BADPRIO;
            end else begin
              level_jobs  <= jobs[plvl];
              level_pages <= pages[plvl];
              level_wait  <= waits[plvl];
            end
          end
          default: status <= spmq_pkg::ST_OK;
        endcase
      end
      if (state == spmq_pkg::S_DATA) begin
        done            <= 1'b1;
        status          <= spmq_pkg::ST_OK;
        item_tag        <= rd_data.tag;
        item_priority   <= 4'(lvl) + 4'd1;
        item_pages      <= rd_data.pages;
        item_enter_time <= rd_data.enter;
        item_wait       <= '0;
        level_jobs      <= '0;
        level_pages     <= '0;
        level_wait      <= '0;
        queue_count     <= total_w[7:0];
        if (c.mode == spmq_pkg::MODE_POP) begin
          item_wait   <= wait_val;
          waits[lvl]  <= spmq_pkg::sat_add(waits[lvl], wait_val);
          head[lvl]   <= (head[lvl] == LAST_POS) ? ptr_inc : head[lvl] + IW'(1);
          fill[lvl]   <= fill[lvl] - FW'(1);
          total       <= total - TW'(1);
          queue_count <= 8'(total_w - 32'd1);
        end
      end
    end
  end

endmodule

// ----- src/spmq_checker.sv -----
module spmq_checker (
  input logic        clk,
  input logic        rst,
  input logic        done,
  input logic [1:0]  status,
  input logic [15:0] item_tag,
  input logic [3:0]  item_priority,
  input logic [31:0] level_jobs
);

  a_rst_quiet: assert property (@(posedge clk) rst |=> !done)
    else $error("result strobe right after reset");

  a_no_back_to_back: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobes in adjacent cycles");

  a_empty_clean: assert property (@(posedge clk) disable iff (rst)
    (done && status == spmq_pkg::ST_EMPTY) |-> (item_tag == '0 && level_jobs == '0))
    else $error("empty result carries data");

  a_item_ok: assert property (@(posedge clk) disable iff (rst)
    (done && item_priority != '0) |-> status == spmq_pkg::ST_OK)
    else $error("job returned with error status");

endmodule

bind strict_priority_multi_queue spmq_checker u_spmq_checker (
  .clk           (clk),
  .rst           (rst),
  .done          (done),
  .status        (status),
  .item_tag      (item_tag),
  .item_priority (item_priority),
  .level_jobs    (level_jobs)
);

// ----- tb/tb_top.sv -----
`timescale 1ns / 1ps

module tb_top;

  localparam int NLEV = 8;
  localparam int DEPTH = 16;
  localparam int LIMIT = 400000;

  typedef struct packed {
    logic [1:0]  status;
    logic [15:0] tag;
    logic [3:0]  prio;
    logic [15:0] pages;
    logic [31:0] enter;
    logic [31:0] wait_t;
    logic [7:0]  count;
    logic [31:0] ljobs;
    logic [31:0] lpages;
    logic [31:0] lwait;
  } result_t;

  typedef struct packed {
    logic        is_cfg;
    logic [3:0]  cfg;
    logic [2:0]  mode;
    logic [3:0]  prio;
    logic [15:0] pages;
    logic [15:0] tag;
    logic [31:0] now;
  } op_t;

  logic clk = 0;
  logic rst = 1;
  logic start = 0, cfg_valid = 0;
  logic [2:0] mode = 0;
  logic [3:0] priority_level = 0, cfg_data = 0;
  logic [15:0] job_pages = 0, job_tag = 0;
  logic [31:0] now = 0;
  logic busy, cfg_ready, done;
  logic [1:0] status;
  logic [15:0] item_tag, item_pages;
  logic [3:0] item_priority;
  logic [31:0] item_enter_time, item_wait, level_jobs, level_pages, level_wait;
  logic [7:0] queue_count;

  strict_priority_multi_queue DUT (.*);

  always #4 clk = ~clk;

  // predictor state
  spmq_pkg::slot_t mem_q [NLEV][DEPTH];
  logic [3:0]  hd [NLEV], tl [NLEV];
  logic [4:0]  fill [NLEV];
  logic [31:0] tot_jobs [NLEV], tot_pages [NLEV], tot_wait [NLEV];
  logic [3:0]  lvls;

  op_t     pending [$];
  result_t expected_results [$];
  int      errors = 0;
  int      cycles = 0;
  int      gap = 0;
  int      cfg_hold = 0;
  logic    stim_done = 0;
  logic [31:0] clock_now = 0;
  logic    busy_s, cfg_ready_s;

  function automatic logic [31:0] sadd(logic [31:0] a, logic [31:0] b);
    logic [32:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[32] ? '1 : s[31:0];
  endfunction

  function automatic result_t predict_queue(op_t c);
    result_t r;
    int eff, l;
    logic [3:0] pos;
    logic ok, found;
    logic [31:0] w;
    int n;
    r = '0;
    eff = (int'(lvls) > NLEV) ? NLEV : int'(lvls);
    ok = (c.prio >= 4'd1) && (int'(c.prio) <= eff);
    found = 0;
    l = 0;
    if (c.mode == spmq_pkg::MODE_PUSH) begin
      if (!ok) r.status = spmq_pkg::ST_BADPRIO;
      else begin
        l = int'(c.prio) - 1;
        if (fill[l] >= DEPTH) r.status = spmq_pkg::ST_FULL;
        else begin
          mem_q[l][tl[l]] = '{tag: c.tag, pages: c.pages, enter: c.now};
          tl[l] = tl[l] + 4'd1;
          fill[l]++;
          tot_jobs[l] = sadd(tot_jobs[l], 32'd1);
          tot_pages[l] = sadd(tot_pages[l], 32'(c.pages));
        end
      end
    end else if (c.mode == spmq_pkg::MODE_POP || c.mode == spmq_pkg::MODE_PEEKF ||
                 c.mode == spmq_pkg::MODE_PEEKB) begin
      if (c.mode == spmq_pkg::MODE_PEEKB) begin
        for (int i = eff; i > 0 && !found; i--)
          if (fill[i-1] != 0) begin l = i - 1; found = 1; end
      end else begin
        for (int i = 0; i < eff && !found; i++)
          if (fill[i] != 0) begin l = i; found = 1; end
      end
      if (!found) r.status = spmq_pkg::ST_EMPTY;
      else begin
        pos = (c.mode == spmq_pkg::MODE_PEEKB) ? tl[l] - 4'd1 : hd[l];
        r.tag = mem_q[l][pos].tag;
        r.prio = 4'(l + 1);
        r.pages = mem_q[l][pos].pages;
        r.enter = mem_q[l][pos].enter;
        if (c.mode == spmq_pkg::MODE_POP) begin
          w = c.now - mem_q[l][pos].enter;
          r.wait_t = w;
          tot_wait[l] = sadd(tot_wait[l], w);
          hd[l] = hd[l] + 4'd1;
          fill[l]--;
        end
      end
    end else if (c.mode == spmq_pkg::MODE_STATS) begin
      if (!ok) r.status = spmq_pkg::ST_BADPRIO;
      else begin
        l = int'(c.prio) - 1;
        r.ljobs = tot_jobs[l];
        r.lpages = tot_pages[l];
        r.lwait = tot_wait[l];
      end
    end
    n = 0;
    for (int i = 0; i < NLEV; i++) n += int'(fill[i]);
    r.count = n[7:0];
    return r;
  endfunction

  always @(posedge clk) begin
    busy_s <= busy;
    cfg_ready_s <= cfg_ready;
  end

  task automatic next_item(output logic issued);
    op_t c;
    issued = 0;
    if (gap > 0) begin
      gap--;
      return;
    end
    if (pending.size() == 0) begin
      stim_done = 1;
      return;
    end
    if (pending[0].is_cfg) begin
      if (expected_results.size() != 0 || start) return;
      if (cfg_hold < 8) begin
        cfg_hold++;
        return;
      end
      cfg_hold = 0;
      c = pending.pop_front();
      cfg_data <= c.cfg;
      cfg_valid <= 1;
      return;
    end
    c = pending.pop_front();
    mode <= c.mode;
    priority_level <= c.prio;
    job_pages <= c.pages;
    job_tag <= c.tag;
    now <= c.now;
    issued = 1;
    case ($urandom_range(0, 9))
      0, 1, 2: gap = $urandom_range(1, 3);
      3: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 40) : 0;
      default: gap = 0;
    endcase
  endtask

  // driver
  always @(negedge clk) begin
    logic issued;
    cycles <= cycles + 1;
    if (!rst) begin
      if (cfg_valid && cfg_ready_s) cfg_valid <= 0;
      else if (cfg_valid) ;
      else if (!start || !busy_s) begin
        next_item(issued);
        start <= issued;
      end
    end
  end

  // accept-time prediction
  always @(posedge clk) begin
    if (!rst) begin
      if (start && !busy) expected_results.push_back(predict_queue(
          '{is_cfg: 0, cfg: 0, mode: mode, prio: priority_level, pages: job_pages,
            tag: job_tag, now: now}));
      if (cfg_valid && cfg_ready) lvls = cfg_data;
    end
  end

  // monitor
  always @(posedge clk) begin
    result_t got, exp_r;
    if (!rst && done) begin
      got = '{status, item_tag, item_priority, item_pages, item_enter_time, item_wait,
              queue_count, level_jobs, level_pages, level_wait};
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, got);
        errors++;
      end else begin
        exp_r = expected_results.pop_front();
        if (got !== exp_r) begin
          $display("%0t: mismatch status exp %0d got %0d", $time, exp_r.status, got.status);
          $display("  item exp %h got %h", {exp_r.tag, exp_r.prio, exp_r.pages, exp_r.enter,
                   exp_r.wait_t}, {got.tag, got.prio, got.pages, got.enter, got.wait_t});
          $display("  count exp %0d got %0d stats exp %h got %h", exp_r.count, got.count,
                   {exp_r.ljobs, exp_r.lpages, exp_r.lwait},
                   {got.ljobs, got.lpages, got.lwait});
          errors++;
        end
      end
    end
  end

  function automatic op_t mk(int m, int p, int pg, int tg, logic [31:0] t);
    return '{is_cfg: 1'b0, cfg: 4'd0, mode: 3'(m), prio: 4'(p), pages: 16'(pg),
             tag: 16'(tg), now: t};
  endfunction

  function automatic op_t mkcfg(int v);
    return '{is_cfg: 1'b1, cfg: 4'(v), mode: 3'd0, prio: 4'd0, pages: 16'd0, tag: 16'd0,
             now: 32'd0};
  endfunction

  task automatic add_phase(int n, int lv_max);
    int k;
    int m;
    for (int i = 0; i < n; i++) begin
      clock_now += $urandom_range(0, 50);
      k = $urandom_range(0, 99);
      if (k < 45) m = spmq_pkg::MODE_PUSH;
      else if (k < 75) m = spmq_pkg::MODE_POP;
      else if (k < 83) m = spmq_pkg::MODE_PEEKF;
      else if (k < 90) m = spmq_pkg::MODE_PEEKB;
      else if (k < 97) m = spmq_pkg::MODE_STATS;
      else m = $urandom_range(5, 7);
      pending.push_back(mk(m,
          ($urandom_range(0, 19) == 0) ? $urandom_range(0, 15) : $urandom_range(1, lv_max),
          ($urandom_range(0, 9) == 0) ? 65535 : $urandom_range(0, 65535),
          $urandom_range(0, 65535),
          ($urandom_range(0, 29) == 0) ? $urandom() : clock_now));
    end
  endtask

  initial begin
    for (int i = 0; i < NLEV; i++) begin
      hd[i] = 0; tl[i] = 0; fill[i] = 0;
      tot_jobs[i] = 0; tot_pages[i] = 0; tot_wait[i] = 0;
    end
    lvls = 8;
    // directed
    pending.push_back(mk(spmq_pkg::MODE_POP, 1, 0, 0, 0));
    pending.push_back(mk(spmq_pkg::MODE_PEEKF, 1, 0, 0, 0));
    pending.push_back(mk(spmq_pkg::MODE_PEEKB, 1, 0, 0, 0));
    pending.push_back(mk(spmq_pkg::MODE_PUSH, 0, 5, 5, 1));
    pending.push_back(mk(spmq_pkg::MODE_PUSH, 9, 5, 5, 1));
    pending.push_back(mk(spmq_pkg::MODE_PUSH, 15, 5, 5, 1));
    pending.push_back(mk(spmq_pkg::MODE_PUSH, 8, 65535, 65535, 32'hFFFF_FFF0));
    pending.push_back(mk(spmq_pkg::MODE_PUSH, 1, 0, 0, 32'hFFFF_FFFF));
    pending.push_back(mk(spmq_pkg::MODE_PEEKB, 0, 0, 0, 0));
    pending.push_back(mk(spmq_pkg::MODE_PEEKF, 0, 0, 0, 0));
    pending.push_back(mk(spmq_pkg::MODE_POP, 0, 0, 0, 32'h10));
    pending.push_back(mk(spmq_pkg::MODE_POP, 0, 0, 0, 32'h5));
    pending.push_back(mk(spmq_pkg::MODE_STATS, 8, 0, 0, 0));
    pending.push_back(mk(spmq_pkg::MODE_STATS, 0, 0, 0, 0));
    pending.push_back(mk(5, 3, 1, 1, 1));
    pending.push_back(mk(7, 3, 1, 1, 1));
    for (int i = 0; i < 17; i++) pending.push_back(mk(spmq_pkg::MODE_PUSH, 2, 65535, i, i));
    pending.push_back(mk(spmq_pkg::MODE_STATS, 2, 0, 0, 0));
    pending.push_back(mk(spmq_pkg::MODE_PUSH, 3, 7, 7, 0));
    pending.push_back(mkcfg(2));
    pending.push_back(mk(spmq_pkg::MODE_PEEKB, 0, 0, 0, 0));
    pending.push_back(mk(spmq_pkg::MODE_PUSH, 3, 7, 7, 0));
    pending.push_back(mkcfg(0));
    pending.push_back(mk(spmq_pkg::MODE_PUSH, 1, 1, 1, 1));
    pending.push_back(mk(spmq_pkg::MODE_POP, 1, 0, 0, 1));
    pending.push_back(mk(spmq_pkg::MODE_STATS, 1, 0, 0, 0));
    pending.push_back(mkcfg(15));
    add_phase(300, 8);
    pending.push_back(mkcfg(1));
    add_phase(150, 2);
    pending.push_back(mkcfg(4));
    add_phase(250, 5);
    pending.push_back(mkcfg(8));
    add_phase(350, 8);
    pending.push_back(mkcfg(0));
    add_phase(40, 2);
    pending.push_back(mkcfg(12));
    add_phase(230, 8);
    repeat (7) @(posedge clk);
    @(negedge clk) rst <= 0;
    wait (stim_done && !start && expected_results.size() == 0);
    repeat (20) @(posedge clk);
    if (errors == 0) $display("tb_top: done, clean");
    else $display("tb_top: done, errors");
    $finish;
  end

  always @(posedge clk) begin
    if (cycles > LIMIT) begin
      $display("tb_top: done, errors");
      $finish;
    end
  end

endmodule
